// ----- hdl/rmd_pkg.sv -----
package rmd_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned NumChain = 5;
   localparam int unsigned NumWords = 16;
   localparam int unsigned NumSteps = 80;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [6:0] step_type;
   typedef logic [3:0] sel_type;
   typedef logic [4:0] rot_type;
   typedef logic [2:0] windex_type;

   typedef struct packed {
      logic load_byte;
      logic load_pad;
      logic load_length;
      logic start;
      logic clear_all;
   } rmd_cmd_type;

   typedef struct packed {
      logic busy;
   } rmd_status_type;

   localparam word_type InitCv0 = 32'h67452301;
   localparam word_type InitCv1 = 32'hefcdab89;
   localparam word_type InitCv2 = 32'h98badcfe;
   localparam word_type InitCv3 = 32'h10325476;
   localparam word_type InitCv4 = 32'hc3d2e1f0;

   localparam logic [NumSteps*4-1:0] SelL = {
      4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
      4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
      4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
      4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
      4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13};
   localparam logic [NumSteps*4-1:0] SelR = {
      4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
      4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
      4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
      4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
      4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11};
   localparam logic [NumSteps*5-1:0] RotL = {
      5'd11,5'd14,5'd15,5'd12,5'd5,5'd8,5'd7,5'd9,5'd11,5'd13,5'd14,5'd15,5'd6,5'd7,5'd9,5'd8,
      5'd7,5'd6,5'd8,5'd13,5'd11,5'd9,5'd7,5'd15,5'd7,5'd12,5'd15,5'd9,5'd11,5'd7,5'd13,5'd12,
      5'd11,5'd13,5'd6,5'd7,5'd14,5'd9,5'd13,5'd15,5'd14,5'd8,5'd13,5'd6,5'd5,5'd12,5'd7,5'd5,
      5'd11,5'd12,5'd14,5'd15,5'd14,5'd15,5'd9,5'd8,5'd9,5'd14,5'd5,5'd6,5'd8,5'd6,5'd5,5'd12,
      5'd9,5'd15,5'd5,5'd11,5'd6,5'd8,5'd13,5'd12,5'd5,5'd12,5'd13,5'd14,5'd11,5'd8,5'd5,5'd6};
   localparam logic [NumSteps*5-1:0] RotR = {
      5'd8,5'd9,5'd9,5'd11,5'd13,5'd15,5'd15,5'd5,5'd7,5'd7,5'd8,5'd11,5'd14,5'd14,5'd12,5'd6,
      5'd9,5'd13,5'd15,5'd7,5'd12,5'd8,5'd9,5'd11,5'd7,5'd7,5'd12,5'd7,5'd6,5'd15,5'd13,5'd11,
      5'd9,5'd7,5'd15,5'd11,5'd8,5'd6,5'd6,5'd14,5'd12,5'd13,5'd5,5'd14,5'd13,5'd13,5'd7,5'd5,
      5'd15,5'd5,5'd8,5'd11,5'd14,5'd14,5'd6,5'd14,5'd6,5'd9,5'd12,5'd9,5'd12,5'd5,5'd15,5'd8,
      5'd8,5'd5,5'd12,5'd9,5'd12,5'd5,5'd14,5'd15,5'd13,5'd11,5'd11,5'd8,5'd5,5'd6,5'd15,5'd13};

   function automatic sel_type sel_l(input step_type j);
      return SelL[(NumSteps-1-int'(j))*4 +: 4];
   endfunction

   function automatic sel_type sel_r(input step_type j);
      return SelR[(NumSteps-1-int'(j))*4 +: 4];
   endfunction

   function automatic rot_type rot_l(input step_type j);
      return RotL[(NumSteps-1-int'(j))*5 +: 5];
   endfunction

   function automatic rot_type rot_r(input step_type j);
      return RotR[(NumSteps-1-int'(j))*5 +: 5];
   endfunction

   function automatic word_type add_l(input logic [2:0] g);
      case (g)
         3'd0: return 32'h00000000;
         3'd1: return 32'h5a827999;
         3'd2: return 32'h6ed9eba1;
         3'd3: return 32'h8f1bbcdc;
         default: return 32'ha953fd4e;
      endcase
   endfunction

   function automatic word_type add_r(input logic [2:0] g);
      case (g)
         3'd0: return 32'h50a28be6;
         3'd1: return 32'h5c4dd124;
         3'd2: return 32'h6d703ef3;
         3'd3: return 32'h7a6d76e9;
         default: return 32'h00000000;
      endcase
   endfunction

   function automatic word_type mix(input logic [2:0] g, input word_type x,
                                    input word_type y, input word_type z);
      case (g)
         3'd0: return x ^ y ^ z;
         3'd1: return (x & y) | (~x & z);
         3'd2: return (x | ~y) ^ z;
         3'd3: return (x & z) | (y & ~z);
         default: return x ^ (y | ~z);
      endcase
   endfunction

   function automatic word_type rotl(input word_type x, input rot_type n);
      logic [2*WordWidth-1:0] w;
      begin
         w = {x, x} << n;
         return w[2*WordWidth-1 -: WordWidth];
      end
   endfunction

endpackage

// ----- hdl/rmd_stream_if.sv -----
interface rmd_stream_if #(parameter int unsigned Width = 1);
   logic valid;
   logic ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/rmd_datapath.sv -----
module rmd_datapath (
   input  logic                  clock,
   input  rmd_pkg::rmd_cmd_type  cmd,
   input  logic [7:0]            data_byte,
   input  rmd_pkg::windex_type   out_index,
   output rmd_pkg::word_type     out_word,
   output logic                  pad_two
);
   import rmd_pkg::*;

   word_type cv_ff [NumChain];
   word_type cv_in [NumChain];
   word_type blk_ff [NumWords];
   word_type blk_in [NumWords];
   word_type al_ff, bl_ff, cl_ff, dl_ff, el_ff;
   word_type ar_ff, br_ff, cr_ff, dr_ff, er_ff;
   word_type al_in, bl_in, cl_in, dl_in, el_in;
   word_type ar_in, br_in, cr_in, dr_in, er_in;
   logic [31:0] count_ff, count_in;
   step_type step_ff, step_in;
   logic run_ff, run_in;
   logic [2:0] g;
   word_type tl, tr;
   logic [5:0] pos;

   assign pos = count_ff[5:0];
   assign pad_two = pos > 6'd55;
   assign out_word = cv_ff[out_index];
   assign g = step_ff[6:4];

   assign tl = rotl(al_ff + mix(g, bl_ff, cl_ff, dl_ff) + blk_ff[sel_l(step_ff)] + add_l(g),
                    rot_l(step_ff)) + el_ff;
   assign tr = rotl(ar_ff + mix(3'd4 - g, br_ff, cr_ff, dr_ff) + blk_ff[sel_r(step_ff)]
                    + add_r(g), rot_r(step_ff)) + er_ff;

   always_comb begin
      cv_in = cv_ff;
      blk_in = blk_ff;
      count_in = count_ff;
      step_in = step_ff;
      run_in = run_ff;
      {al_in, bl_in, cl_in, dl_in, el_in} = {al_ff, bl_ff, cl_ff, dl_ff, el_ff};
      {ar_in, br_in, cr_in, dr_in, er_in} = {ar_ff, br_ff, cr_ff, dr_ff, er_ff};
      if (cmd.load_byte) begin
         blk_in[pos[5:2]] = blk_ff[pos[5:2]] | (word_type'(data_byte) << {pos[1:0], 3'b000});
         count_in = count_ff + 32'd1;
      end
      if (cmd.load_pad) begin
         blk_in[pos[5:2]] = blk_ff[pos[5:2]] | (word_type'(8'h80) << {pos[1:0], 3'b000});
      end
      if (cmd.load_length) begin
         blk_in[14] = {count_ff[28:0], 3'b000};
         blk_in[15] = {29'd0, count_ff[31:29]};
      end
      if (cmd.start) begin
         run_in = 1'b1;
         step_in = '0;
         {al_in, bl_in, cl_in, dl_in, el_in} = {cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3], cv_ff[4]};
         {ar_in, br_in, cr_in, dr_in, er_in} = {cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3], cv_ff[4]};
      end else if (run_ff) begin
         al_in = el_ff; el_in = dl_ff; dl_in = rotl(cl_ff, 5'd10); cl_in = bl_ff; bl_in = tl;
         ar_in = er_ff; er_in = dr_ff; dr_in = rotl(cr_ff, 5'd10); cr_in = br_ff; br_in = tr;
         step_in = step_ff + 7'd1;
         if (step_ff == step_type'(NumSteps - 1)) begin
            run_in = 1'b0;
            cv_in[0] = cv_ff[1] + bl_ff + rotl(cr_ff, 5'd10);
            cv_in[1] = cv_ff[2] + rotl(cl_ff, 5'd10) + dr_ff;
            cv_in[2] = cv_ff[3] + dl_ff + er_ff;
            cv_in[3] = cv_ff[4] + el_ff + tr;
            cv_in[4] = cv_ff[0] + tl + br_ff;
            for (int i = 0; i < NumWords; i++) blk_in[i] = '0;
         end
      end
      if (cmd.clear_all) begin
         cv_in = '{InitCv0, InitCv1, InitCv2, InitCv3, InitCv4};
         for (int i = 0; i < NumWords; i++) blk_in[i] = '0;
         count_in = '0;
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cv_ff <= cv_in;
      blk_ff <= blk_in;
      count_ff <= count_in;
      step_ff <= step_in;
      run_ff <= run_in;
      {al_ff, bl_ff, cl_ff, dl_ff, el_ff} <= {al_in, bl_in, cl_in, dl_in, el_in};
      {ar_ff, br_ff, cr_ff, dr_ff, er_ff} <= {ar_in, br_in, cr_in, dr_in, er_in};
   end

endmodule

// ----- hdl/rmd_control.sv -----
module rmd_control (
   input  logic                  clock,
   input  logic                  reset,
   rmd_stream_if.sink            req,
   rmd_stream_if.source          rsp,
   input  logic                  pad_two,
   input  rmd_pkg::word_type     out_word,
   output rmd_pkg::windex_type   out_index,
   output rmd_pkg::rmd_cmd_type  cmd
);
   import rmd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_BLOCK, S_PAD, S_FINAL, S_WAIT, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;
   windex_type idx_ff, idx_in;
   logic last_ff, last_in;
   logic accept;
   logic in_valid, in_last;

   assign {in_last, in_valid} = req.payload[9:8];
   assign req.ready = (state_ff == S_IDLE) && !reset;
   assign accept = req.valid && req.ready;
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.payload = {(idx_ff == 3'd4), idx_ff, out_word};
   assign out_index = idx_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      last_in = last_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_byte = in_valid;
               last_in = in_last;
               if (in_valid && (cnt_ff == 7'd63)) begin
                  cmd.start = 1'b1;
                  state_in = S_BLOCK;
                  cnt_in = '0;
               end else begin
                  if (in_valid) cnt_in = cnt_ff + 7'd1;
                  if (in_last) state_in = S_PAD;
               end
            end
         end
         S_BLOCK: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd80) begin
               cnt_in = '0;
               state_in = last_ff ? S_PAD : S_IDLE;
            end
         end
         S_PAD: begin
            cmd.load_pad = 1'b1;
            cmd.start = 1'b1;
            cmd.load_length = !pad_two;
            cnt_in = '0;
            state_in = pad_two ? S_FINAL : S_WAIT;
         end
         S_FINAL: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd80) begin
               cmd.load_length = 1'b1;
               cmd.start = 1'b1;
               cnt_in = '0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd80) begin
               idx_in = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  cmd.clear_all = 1'b1;
                  cnt_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (reset) cmd.clear_all = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         last_ff <= last_in;
      end
   end

endmodule

// ----- hdl/ripemd160_hash_unit.sv -----
// RIPEMD-160 hash unit. Each request carries one message byte, a flag that
// says whether the byte is present, and a last flag that ends the message.
// A byte is accepted whenever ready is high; after every 64th byte the
// compression runs one step of both lines per cycle, and ready stays low
// while it runs. The 80-step compression loop sets the rate.
// On a last request the unit pads the block, runs one or two compressions
// (two when more than 55 bytes of the block are in use), and then offers
// the five digest words on the response channel, word 0 first, with the
// last_word flag set on word 4. While the receiver stalls, the current
// word is held and no new request is accepted. After the fifth word is
// taken, the unit returns to the initial chaining value and takes the
// next message.
// Reset is synchronous and active high; it restores the initial chaining
// value, clears the block and the byte count, and drops all pending work.
module ripemd160_hash_unit (
   input  logic          clock,
   input  logic          reset,
   rmd_stream_if.sink    req,
   rmd_stream_if.source  rsp
);
   import rmd_pkg::*;

   rmd_cmd_type cmd;
   windex_type out_index;
   word_type out_word;
   logic pad_two;

   rmd_control u_control (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .pad_two(pad_two), .out_word(out_word), .out_index(out_index), .cmd(cmd)
   );

   rmd_datapath u_datapath (
      .clock(clock), .cmd(cmd), .data_byte(req.payload[7:0]),
      .out_index(out_index), .out_word(out_word), .pad_two(pad_two)
   );

endmodule
